// ===== hw/rtl/saeq_pkg.sv =====
// ----------------------------------------------------------------------------
// saeq_pkg
// shared types, codes and helpers for the sorted alarm event queue
// ----------------------------------------------------------------------------
package saeq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int KEY_W           = 32;
  localparam int LABEL_W         = 64;
  localparam logic [5:0] LAST_SECOND = 6'd59;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOMATCH = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_POP    = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EXEC = 2'd2
  } state_t;

  typedef struct packed {
    cell_op_t op;
    logic     scan_clr;
    logic     scan_en;
  } cell_ctl_t;

  function automatic logic [KEY_W-1:0] pack_key(
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day,
    input logic [4:0]  hour,
    input logic [5:0]  minute
  );
    return {year, month, day, hour, minute};
  endfunction

endpackage

// ===== hw/rtl/saeq_cell.sv =====
// ----------------------------------------------------------------------------
// saeq_cell
// one slot of the sorted chain: holds a key and label, shifts to or from
// its neighbors and carries the first-match search one cell per cycle
// ----------------------------------------------------------------------------
module saeq_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  saeq_pkg::cell_ctl_t         ctl,
  input  logic                        occ,
  input  logic [saeq_pkg::KEY_W-1:0]  new_key,
  input  logic [saeq_pkg::LABEL_W-1:0] new_label,
  input  logic                        left_ge,
  input  logic                        left_seen,
  input  logic [saeq_pkg::KEY_W-1:0]  left_key,
  input  logic [saeq_pkg::LABEL_W-1:0] left_label,
  input  logic [saeq_pkg::KEY_W-1:0]  right_key,
  input  logic [saeq_pkg::LABEL_W-1:0] right_label,
  output logic                        ge,
  output logic                        seen,
  output logic [saeq_pkg::KEY_W-1:0]  key,
  output logic [saeq_pkg::LABEL_W-1:0] label
);

  logic prior_seen;
  logic match;

  // empty slots count as not below the new key so insertion lands there
  assign ge    = !occ || (key >= new_key);
  assign match = occ && (key == new_key) && (label == new_label);
  assign seen  = prior_seen || match;

  always_ff @(posedge clk) begin
    if (rst) begin
      prior_seen <= 1'b0;
    end else if (ctl.scan_clr) begin
      prior_seen <= 1'b0;
    end else if (ctl.scan_en) begin
      prior_seen <= left_seen;
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      saeq_pkg::OP_INSERT: begin
        if (left_ge) begin
          key   <= left_key;
          label <= left_label;
        end else if (ge) begin
          key   <= new_key;
          label <= new_label;
        end
      end
      saeq_pkg::OP_DELETE: begin
        if (seen) begin
          key   <= right_key;
          label <= right_label;
        end
      end
      saeq_pkg::OP_POP: begin
        key   <= right_key;
        label <= right_label;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/sorted_alarm_event_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_alarm_event_queue_core
// sorted reminder queue with time-match alarm, built as a chain of cells
// ----------------------------------------------------------------------------
// an insert, tick or ignored item goes from idle to execute; a remove first runs
// the scan state, rippling the first-match search down the cell chain one cell
// per cycle. the response is registered on leaving execute, which waits while
// the output is stalled. items go one at a time, each done before the next.
// reset clears the entry count, the search flags and the control; cell
// storage is not reset and is only read below the entry count.
module sorted_alarm_event_queue_core #(
  parameter int QUEUE_DEPTH = saeq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  req_type,
  input  logic [11:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [5:0]  second,
  input  logic [63:0] label,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic        alarm,
  output logic [63:0] alarm_label,
  output logic [4:0]  pending_count
);

  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SCAN_W = $clog2(QUEUE_DEPTH);

  saeq_pkg::state_t    state, state_next;
  saeq_pkg::req_t      req_kind;
  saeq_pkg::cell_ctl_t ctl;

  logic [SCAN_W-1:0]            scan_cnt;
  logic [saeq_pkg::KEY_W-1:0]   key_q;
  logic [saeq_pkg::LABEL_W-1:0] label_q;
  logic [5:0]                   sec_q;
  logic [CNT_W-1:0]             count, count_next;
  logic [CNT_W+4:0]             pend_wide;

  logic                         rsp_load;
  saeq_pkg::status_t            status_res;
  logic                         alarm_res;
  logic [saeq_pkg::LABEL_W-1:0] alabel_res;

  logic                         cell_ge   [QUEUE_DEPTH];
  logic                         cell_seen [QUEUE_DEPTH];
  logic [saeq_pkg::KEY_W-1:0]   cell_key  [QUEUE_DEPTH];
  logic [saeq_pkg::LABEL_W-1:0] cell_label[QUEUE_DEPTH];

  // cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                         l_ge, l_seen, occ;
    logic [saeq_pkg::KEY_W-1:0]   l_key, r_key;
    logic [saeq_pkg::LABEL_W-1:0] l_label, r_label;

    assign occ = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign l_ge    = 1'b0;
      assign l_seen  = 1'b0;
      assign l_key   = cell_key[i];
      assign l_label = cell_label[i];
    end else begin : g_mid
      assign l_ge    = cell_ge[i-1];
      assign l_seen  = cell_seen[i-1];
      assign l_key   = cell_key[i-1];
      assign l_label = cell_label[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_key   = cell_key[i];
      assign r_label = cell_label[i];
    end else begin : g_body
      assign r_key   = cell_key[i+1];
      assign r_label = cell_label[i+1];
    end

    saeq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .occ         (occ),
      .new_key     (key_q),
      .new_label   (label_q),
      .left_ge     (l_ge),
      .left_seen   (l_seen),
      .left_key    (l_key),
      .left_label  (l_label),
      .right_key   (r_key),
      .right_label (r_label),
      .ge          (cell_ge[i]),
      .seen        (cell_seen[i]),
      .key         (cell_key[i]),
      .label       (cell_label[i])
    );
  end

  assign req_stall = (state != saeq_pkg::ST_IDLE) || (rsp_valid && rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= saeq_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || state != saeq_pkg::ST_SCAN) begin
      scan_cnt <= '0;
    end else begin
      scan_cnt <= scan_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_kind <= saeq_pkg::req_t'(req_type);
      key_q    <= saeq_pkg::pack_key(year, month, day, hour, minute);
      label_q  <= label;
      sec_q    <= second;
    end
  end

  always_comb begin
    state_next   = state;
    ctl.op       = saeq_pkg::OP_HOLD;
    ctl.scan_clr = 1'b0;
    ctl.scan_en  = 1'b0;
    rsp_load     = 1'b0;
    status_res   = saeq_pkg::STAT_DONE;
    alarm_res    = 1'b0;
    alabel_res   = '0;
    count_next   = count;
    case (state)
      saeq_pkg::ST_IDLE: begin
        if (req_valid && !req_stall) begin
          ctl.scan_clr = 1'b1;
          if (saeq_pkg::req_t'(req_type) == saeq_pkg::REQ_REMOVE) begin
            state_next = saeq_pkg::ST_SCAN;
          end else begin
            state_next = saeq_pkg::ST_EXEC;
          end
        end
      end
      saeq_pkg::ST_SCAN: begin
        ctl.scan_en = 1'b1;
        if (scan_cnt == SCAN_W'(QUEUE_DEPTH - 1)) begin
          state_next = saeq_pkg::ST_EXEC;
        end
      end
      saeq_pkg::ST_EXEC: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = saeq_pkg::ST_IDLE;
          case (req_kind)
            saeq_pkg::REQ_INSERT: begin
              if (count == CNT_W'(QUEUE_DEPTH)) begin
                status_res = saeq_pkg::STAT_FULL;
              end else begin
                ctl.op     = saeq_pkg::OP_INSERT;
                count_next = count + 1'b1;
              end
            end
            saeq_pkg::REQ_REMOVE: begin
              // seen at the tail means some cell matched
              if (cell_seen[QUEUE_DEPTH-1]) begin
                ctl.op     = saeq_pkg::OP_DELETE;
                count_next = count - 1'b1;
              end else begin
                status_res = saeq_pkg::STAT_NOMATCH;
              end
            end
            saeq_pkg::REQ_TICK: begin
              if (count == '0) begin
                status_res = saeq_pkg::STAT_EMPTY;
              end else if (cell_key[0] == key_q) begin
                alarm_res  = 1'b1;
                alabel_res = cell_label[0];
                if (sec_q == saeq_pkg::LAST_SECOND) begin
                  ctl.op     = saeq_pkg::OP_POP;
                  count_next = count - 1'b1;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = saeq_pkg::ST_IDLE;
      end
    endcase
  end

  assign pend_wide = {5'd0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      status        <= status_res;
      alarm         <= alarm_res;
      alarm_label   <= alabel_res;
      pending_count <= pend_wide[4:0];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + 1'b1 ||
                     count == $past(count) - 1'b1))
    else $error("entry count moved by more than one");

  a_rsp_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == saeq_pkg::ST_EXEC)
    else $error("response raised outside execute");

  a_alarm_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && alarm |-> status == saeq_pkg::STAT_DONE)
    else $error("alarm with failing status");

  a_scan_leads_exec: assert property (@(posedge clk) disable iff (rst)
    state == saeq_pkg::ST_SCAN && scan_cnt == SCAN_W'(QUEUE_DEPTH - 1)
    |=> state == saeq_pkg::ST_EXEC)
    else $error("search pass did not end in execute");
`endif

endmodule
